/* src/ltc_pkg.sv */
`default_nettype none

package ltc_pkg;

    typedef enum logic [2:0] {
        S_START,
        S_LT,
        S_GT,
        S_BANG,
        S_EQ,
        S_IDENT,
        S_INT,
        S_FLOAT
    } t_scan_state;

    typedef enum logic [3:0] {
        CL_LE      = 4'd0,
        CL_LT      = 4'd1,
        CL_GE      = 4'd2,
        CL_GT      = 4'd3,
        CL_NE      = 4'd4,
        CL_ASSIGN  = 4'd5,
        CL_EQEQ    = 4'd6,
        CL_IDENT   = 4'd7,
        CL_KEYWORD = 4'd8,
        CL_INT     = 4'd9,
        CL_FLOAT   = 4'd10,
        CL_ARITH   = 4'd11,
        CL_DELIM   = 4'd12,
        CL_SPECIAL = 4'd13
    } t_token_class;

    localparam logic [2:0] KW_VOID  = 3'd0;
    localparam logic [2:0] KW_FLOAT = 3'd1;
    localparam logic [2:0] KW_INT   = 3'd2;
    localparam logic [2:0] KW_IF    = 3'd3;
    localparam logic [2:0] KW_ELSE  = 3'd4;
    localparam logic [2:0] KW_MAIN  = 3'd5;

    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_NL    = 8'h0A;

    // keyword text, first character in the low byte
    localparam logic [39:0] KT_VOID  = 40'({"d", "i", "o", "v"});
    localparam logic [39:0] KT_FLOAT = {"t", "a", "o", "l", "f"};
    localparam logic [39:0] KT_INT   = 40'({"t", "n", "i"});
    localparam logic [39:0] KT_IF    = 40'({"f", "i"});
    localparam logic [39:0] KT_ELSE  = 40'({"e", "s", "l", "e"});
    localparam logic [39:0] KT_MAIN  = 40'({"n", "i", "a", "m"});

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        t_token_class token_class;
        logic [2:0]   keyword_index;
        logic [6:0]   token_length;
        logic [7:0]   token_char;
        logic         length_saturated;
        logic         last_of_run;
    } t_token;

    typedef struct packed {
        logic [1:0] push_count;
        t_token     tok0;
        t_token     tok1;
    } t_scan_out;

    function automatic logic is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return !c[7] && (l >= "a") && (l <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // returns {hit, index}
    function automatic logic [3:0] kw_lookup(input logic [39:0] pfx, input logic [6:0] len);
        logic [3:0] r;
        r = 4'b0;
        if      (len == 7'd4 && pfx == KT_VOID)  r = {1'b1, KW_VOID};
        else if (len == 7'd5 && pfx == KT_FLOAT) r = {1'b1, KW_FLOAT};
        else if (len == 7'd3 && pfx == KT_INT)   r = {1'b1, KW_INT};
        else if (len == 7'd2 && pfx == KT_IF)    r = {1'b1, KW_IF};
        else if (len == 7'd4 && pfx == KT_ELSE)  r = {1'b1, KW_ELSE};
        else if (len == 7'd4 && pfx == KT_MAIN)  r = {1'b1, KW_MAIN};
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/lexical_token_classifier_unit.sv */
`default_nettype none
// Channel  Handshake                 Payload
// input    i_in_valid / o_in_ready    i_char_in, i_end_of_input
// output   o_out_valid / i_out_ready  o_token_class, o_keyword_index, o_token_length,
//                                     o_token_char, o_length_saturated, o_last_of_run
//
// One character is accepted per cycle; the scanner state updates on that edge and its
// zero, one or two tokens enter a 4-entry output queue, visible the next cycle.
// The queue drains one token per cycle; input ready drops while it holds more than two.
// Reset is synchronous and clears the scanner state and the queue.
// A stalled output stops input once the queue holds three tokens.

module lexical_token_classifier_unit
    import ltc_pkg::*;
#(
    parameter int MAX_LEXEME_LENGTH = 99
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_end_of_input,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [3:0]      o_token_class,
    output logic [2:0]      o_keyword_index,
    output logic [6:0]      o_token_length,
    output logic [7:0]      o_token_char,
    output logic            o_length_saturated,
    output logic            o_last_of_run
);

    t_scan_out  scan_res;
    t_token     head;
    logic       room2, accept;
    logic [1:0] push_count;

    assign o_in_ready = room2;
    assign accept     = i_in_valid && room2;
    assign push_count = accept ? scan_res.push_count : 2'd0;

    ltc_scanner #(
        .MAX_LEXEME_LENGTH(MAX_LEXEME_LENGTH)
    ) u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_char_in),
        .i_eoi    (i_end_of_input),
        .o_res    (scan_res)
    );

    ltc_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_tok0       (scan_res.tok0),
        .i_tok1       (scan_res.tok1),
        .i_pop        (i_out_ready),
        .o_room2      (room2),
        .o_valid      (o_out_valid),
        .o_tok        (head)
    );

    assign o_token_class      = head.token_class;
    assign o_keyword_index    = head.keyword_index;
    assign o_token_length     = head.token_length;
    assign o_token_char       = head.token_char;
    assign o_length_saturated = head.length_saturated;
    assign o_last_of_run      = head.last_of_run;

endmodule

`default_nettype wire

/* src/ltc_scanner.sv */
`default_nettype none

module ltc_scanner
    import ltc_pkg::*;
#(
    parameter int MAX_LEXEME_LENGTH = 99
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char,
    input  wire logic       i_eoi,
    output t_scan_out       o_res
);

    localparam logic [6:0] MaxLen = 7'(MAX_LEXEME_LENGTH);

    t_scan_state r_state, n_state;
    logic [6:0]  r_len, n_len;
    logic [39:0] r_prefix, n_prefix;
    logic        r_ovf, n_ovf;

    logic [6:0]  app_len;
    logic [39:0] app_prefix;
    logic        app_ovf;
    logic [3:0]  kw;
    t_token      tok_a, tok_b, lex_tok;
    logic        a_vld, b_vld, rescan;
    logic        c_letter, c_digit;

    assign c_letter = is_letter(i_char);
    assign c_digit  = is_digit(i_char);

    // lexeme with the current character appended
    always_comb begin
        app_len    = r_len;
        app_prefix = r_prefix;
        app_ovf    = r_ovf;
        if (r_len < MaxLen) begin
            if (r_len < 7'd5) begin
                app_prefix[8*r_len[2:0] +: 8] = i_char;
            end
            app_len = r_len + 7'd1;
        end else begin
            app_ovf = 1'b1;
        end
    end

    // token for the pending lexeme, keyword check only on an ident
    always_comb begin
        kw = kw_lookup(r_prefix, r_len);
        lex_tok = '0;
        lex_tok.token_length     = r_len;
        lex_tok.length_saturated = r_ovf;
        case (r_state)
            S_INT:   lex_tok.token_class = CL_INT;
            S_FLOAT: lex_tok.token_class = CL_FLOAT;
            default: begin
                if (kw[3] && !r_ovf) begin
                    lex_tok.token_class   = CL_KEYWORD;
                    lex_tok.keyword_index = kw[2:0];
                end else begin
                    lex_tok.token_class = CL_IDENT;
                end
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_prefix = r_prefix;
        n_ovf    = r_ovf;
        tok_a    = '0;
        tok_b    = '0;
        a_vld    = 1'b0;
        b_vld    = 1'b0;
        rescan   = 1'b1;

        case (r_state)
            S_LT, S_GT, S_BANG, S_EQ: begin
                n_state = S_START;
                a_vld   = 1'b1;
                if (!i_eoi && i_char == CH_EQ) begin
                    // two-character operator, the '=' is consumed
                    rescan             = 1'b0;
                    tok_a.token_length = 7'd2;
                    case (r_state)
                        S_LT:    tok_a.token_class = CL_LE;
                        S_GT:    tok_a.token_class = CL_GE;
                        S_BANG:  tok_a.token_class = CL_NE;
                        default: tok_a.token_class = CL_EQEQ;
                    endcase
                end else begin
                    tok_a.token_length = 7'd1;
                    case (r_state)
                        S_LT: begin
                            tok_a.token_class = CL_LT;
                            tok_a.token_char  = CH_LT;
                        end
                        S_GT: begin
                            tok_a.token_class = CL_GT;
                            tok_a.token_char  = CH_GT;
                        end
                        S_BANG: begin
                            tok_a.token_class = CL_SPECIAL;
                            tok_a.token_char  = CH_BANG;
                        end
                        default: begin
                            tok_a.token_class = CL_ASSIGN;
                            tok_a.token_char  = CH_EQ;
                        end
                    endcase
                end
            end
            S_IDENT, S_INT, S_FLOAT: begin
                if (!i_eoi && (c_digit
                        || (r_state == S_IDENT && c_letter)
                        || (r_state == S_INT && i_char == CH_DOT))) begin
                    n_len    = app_len;
                    n_prefix = app_prefix;
                    n_ovf    = app_ovf;
                    rescan   = 1'b0;
                    if (r_state == S_INT && i_char == CH_DOT) begin
                        n_state = S_FLOAT;
                    end
                end else begin
                    a_vld    = 1'b1;
                    tok_a    = lex_tok;
                    n_state  = S_START;
                    n_len    = '0;
                    n_prefix = '0;
                    n_ovf    = 1'b0;
                end
            end
            default: begin
                n_state = S_START;
            end
        endcase

        if (i_eoi) begin
            n_state  = S_START;
            n_len    = '0;
            n_prefix = '0;
            n_ovf    = 1'b0;
        end else if (rescan) begin
            n_state = S_START;
            tok_b.token_length = 7'd1;
            tok_b.token_char   = i_char;
            if (i_char == CH_LT) begin
                n_state = S_LT;
            end else if (i_char == CH_GT) begin
                n_state = S_GT;
            end else if (i_char == CH_BANG) begin
                n_state = S_BANG;
            end else if (i_char == CH_EQ) begin
                n_state = S_EQ;
            end else if (c_letter || c_digit) begin
                n_state  = c_letter ? S_IDENT : S_INT;
                n_len    = 7'd1;
                n_prefix = {32'b0, i_char};
                n_ovf    = 1'b0;
            end else if (i_char == CH_PLUS || i_char == CH_MINUS
                    || i_char == CH_STAR || i_char == CH_SLASH) begin
                b_vld             = 1'b1;
                tok_b.token_class = CL_ARITH;
            end else if (i_char == CH_SEMI) begin
                b_vld             = 1'b1;
                tok_b.token_class = CL_DELIM;
            end else if (i_char != CH_SPACE && i_char != CH_NL) begin
                b_vld             = 1'b1;
                tok_b.token_class = CL_SPECIAL;
            end
        end

        if (b_vld) begin
            tok_b.last_of_run = 1'b1;
        end else begin
            tok_a.last_of_run = 1'b1;
        end
    end

    assign o_res.push_count = {1'b0, a_vld} + {1'b0, b_vld};
    assign o_res.tok0       = a_vld ? tok_a : tok_b;
    assign o_res.tok1       = tok_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_START;
            r_len    <= '0;
            r_prefix <= '0;
            r_ovf    <= 1'b0;
        end else if (i_accept) begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_prefix <= n_prefix;
            r_ovf    <= n_ovf;
        end
    end

endmodule

`default_nettype wire

/* src/ltc_out_queue.sv */
`default_nettype none

module ltc_out_queue
    import ltc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_count,
    input  wire t_token     i_tok0,
    input  wire t_token     i_tok1,
    input  wire logic       i_pop,
    output logic            o_room2,
    output logic            o_valid,
    output t_token          o_tok
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_token          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, n_wr, r_rd, n_rd, wr1;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign wr1     = r_wr + PW'(1);
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    // hold off input unless two more tokens fit
    assign o_room2 = (r_cnt <= CW'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + PW'(i_push_count);
        n_rd  = pop ? r_rd + PW'(1) : r_rd;
        n_cnt = r_cnt + CW'(i_push_count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr1] <= i_tok1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH))
        else $error("output queue count exceeds depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_count != 2'd0) |-> o_room2)
        else $error("push into queue without room");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_cnt == $past(r_cnt) + CW'($past(i_push_count)) - CW'($past(pop)))
        else $error("queue count out of step");

endmodule

`default_nettype wire
